@@ design/hufd_pkg.sv @@
// ----------------------------------------------------------------------------
// hufd_pkg
// Shared types and constants of the table-driven Huffman decoder.
// ----------------------------------------------------------------------------
package hufd_pkg;

  localparam int INDEX_BITS  = 12;
  localparam int TABLE_DEPTH = 1 << INDEX_BITS;
  localparam int SYM_BITS    = 7;
  localparam int LEN_BITS    = 4;
  localparam int ENTRY_BITS  = SYM_BITS + LEN_BITS;
  localparam int BYTE_BITS   = 8;
  localparam int BUF_BITS    = 2 * INDEX_BITS;
  localparam int CNT_BITS    = 5;
  localparam int REM_BITS    = 32;
  localparam int HDR_BITS    = 3;
  localparam int TAKE_BITS   = 4;

  localparam logic [HDR_BITS-1:0] HDR_BYTES = 3'd4;

  localparam logic KIND_TABLE = 1'b0;
  localparam logic KIND_BYTE  = 1'b1;

  typedef struct packed {
    logic                  kind;
    logic [INDEX_BITS-1:0] entry_index;
    logic [SYM_BITS-1:0]   entry_symbol;
    logic [LEN_BITS-1:0]   entry_length;
    logic [BYTE_BITS-1:0]  data_byte;
  } hufd_in_t;

  typedef struct packed {
    logic [SYM_BITS-1:0] symbol;
    logic                last;
    logic                stream_end;
    logic                error;
  } hufd_out_t;

  // Controller to datapath
  typedef struct packed {
    logic table_write;
    logic byte_load;
    logic table_read;
    logic emit;
  } hufd_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic go;
    logic out_free;
    logic last;
  } hufd_stat_t;

endpackage

@@ design/huffman_table_decoder_top.sv @@
// ----------------------------------------------------------------------------
// huffman_table_decoder_top
// Table-driven Huffman decoder with a 4096-entry lookup on 12 peeked bits.
// ----------------------------------------------------------------------------
//
//   channel   signals                          beat carries
//   -------   ------------------------------   ------------------------------
//   item      item_valid / item_stall / item   table entry write or one byte
//   result    result_valid / result_stall /    one decoded symbol or an
//             result                           error flag
//
// A table beat is written directly from idle. A byte beat is first loaded, then
// each decoded symbol takes a decode table read and then an evaluate and emit
// step; a byte that yields none ends after the load with a buffer check that
// finds too few bits to decode.
// Reset (rst, synchronous) clears the stream counters, the bit buffer and the
// output valid; the decode table is undefined until written.
// A stalled result holds the block in its emit step; the last result of a
// beat may wait in the output register while the next beat is taken.
//
module huffman_table_decoder_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  hufd_pkg::hufd_in_t  item,
  output logic                result_valid,
  input  logic                result_stall,
  output hufd_pkg::hufd_out_t result
);
  import hufd_pkg::*;

  hufd_cmd_t  cmd;
  hufd_stat_t stat;

  // Sequence beats and table lookups.
  hufd_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_kind  (item.kind),
    .item_stall (item_stall),
    .stat       (stat),
    .cmd        (cmd)
  );

  // Hold the table, the bit buffer, the counters and the output register.
  hufd_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cmd          (cmd),
    .stat         (stat),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

@@ design/hufd_datapath.sv @@
// ----------------------------------------------------------------------------
// hufd_datapath
// Decode table, bit buffer, stream counters and the output register.
// ----------------------------------------------------------------------------
module hufd_datapath (
  input  logic                clk,
  input  logic                rst,
  input  hufd_pkg::hufd_in_t  item,
  input  hufd_pkg::hufd_cmd_t cmd,
  output hufd_pkg::hufd_stat_t stat,
  output logic                result_valid,
  input  logic                result_stall,
  output hufd_pkg::hufd_out_t result
);
  import hufd_pkg::*;

  logic [ENTRY_BITS-1:0] decode_table [TABLE_DEPTH];
  logic [ENTRY_BITS-1:0] entry;

  logic [BUF_BITS-1:0] bit_buffer;
  logic [CNT_BITS-1:0] buffered_count;
  logic [REM_BITS-1:0] bits_remaining;
  logic [HDR_BITS-1:0] header_bytes_seen;
  logic                discarding;

  logic [BUF_BITS+INDEX_BITS-1:0] peek_wide;
  logic [INDEX_BITS-1:0]          peek;
  logic [REM_BITS-1:0]            count_ext;

  logic [SYM_BITS-1:0] sym;
  logic [LEN_BITS-1:0] len;
  logic [REM_BITS-1:0] len_ext;
  logic                bad;
  logic [CNT_BITS-1:0] count_after;
  logic [REM_BITS-1:0] rem_after;
  logic [REM_BITS-1:0] rem_drop;
  logic                done;
  logic                more;
  logic [BUF_BITS-1:0] keep_mask;

  logic [REM_BITS-1:0]  room;
  logic [TAKE_BITS-1:0] take;
  logic [BUF_BITS-1:0]  appended;
  logic [REM_BITS-1:0]  rem_base;
  logic [REM_BITS-1:0]  rem_header;
  logic [HDR_BITS-1:0]  hdr_inc;

  // Peek the next INDEX_BITS bits, zero-padded when fewer are buffered.
  assign peek_wide = {bit_buffer, {INDEX_BITS{1'b0}}} >> buffered_count;
  assign peek      = peek_wide[INDEX_BITS-1:0];
  assign count_ext = {{(REM_BITS-CNT_BITS){1'b0}}, buffered_count};

  assign stat.go = !discarding && (header_bytes_seen == HDR_BYTES) &&
                   (bits_remaining != '0) &&
                   ((buffered_count >= CNT_BITS'(INDEX_BITS)) ||
                    (count_ext == bits_remaining));

  // Evaluate the entry just read.
  assign sym         = entry[SYM_BITS-1:0];
  assign len         = entry[ENTRY_BITS-1:SYM_BITS];
  assign len_ext     = {{(REM_BITS-LEN_BITS){1'b0}}, len};
  assign bad         = (len == '0) || (len > LEN_BITS'(INDEX_BITS)) ||
                       (len_ext > bits_remaining) ||
                       ({{(CNT_BITS-LEN_BITS){1'b0}}, len} > buffered_count);
  assign count_after = buffered_count - {{(CNT_BITS-LEN_BITS){1'b0}}, len};
  assign rem_after   = bits_remaining - len_ext;
  assign rem_drop    = bits_remaining - count_ext;
  assign done        = (rem_after == '0);
  assign more        = (count_after >= CNT_BITS'(INDEX_BITS)) ||
                       ({{(REM_BITS-CNT_BITS){1'b0}}, count_after} == rem_after);
  assign keep_mask   = ~({BUF_BITS{1'b1}} << count_after);

  assign stat.last     = bad || done || !more;
  assign stat.out_free = !result_valid || !result_stall;

  // Append path for payload bytes.
  assign room     = bits_remaining - count_ext;
  assign take     = (room < REM_BITS'(BYTE_BITS)) ? room[TAKE_BITS-1:0]
                                                  : TAKE_BITS'(BYTE_BITS);
  assign appended = (bit_buffer << take) |
                    {{(BUF_BITS-BYTE_BITS){1'b0}},
                     item.data_byte >> (TAKE_BITS'(BYTE_BITS) - take)};

  // Header path.
  assign rem_base   = (header_bytes_seen == '0) ? '0 : bits_remaining;
  assign rem_header = {rem_base[REM_BITS-BYTE_BITS-1:0], item.data_byte};
  assign hdr_inc    = header_bytes_seen + 1'b1;

  always_ff @(posedge clk) begin
    if (cmd.table_write) begin
      decode_table[item.entry_index] <= {item.entry_length, item.entry_symbol};
    end
    if (cmd.table_read) begin
      entry <= decode_table[peek];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_buffer        <= '0;
      buffered_count    <= '0;
      bits_remaining    <= '0;
      header_bytes_seen <= '0;
      discarding        <= 1'b0;
    end else if (cmd.byte_load) begin
      if (discarding) begin
        if (bits_remaining > REM_BITS'(BYTE_BITS)) begin
          bits_remaining <= bits_remaining - REM_BITS'(BYTE_BITS);
        end else begin
          bits_remaining    <= '0;
          discarding        <= 1'b0;
          header_bytes_seen <= '0;
        end
      end else if (header_bytes_seen < HDR_BYTES) begin
        if (header_bytes_seen == '0) begin
          bit_buffer     <= '0;
          buffered_count <= '0;
        end
        bits_remaining <= rem_header;
        if ((hdr_inc == HDR_BYTES) && (rem_header == '0)) begin
          header_bytes_seen <= '0;
        end else begin
          header_bytes_seen <= hdr_inc;
        end
      end else if (take != '0) begin
        bit_buffer     <= appended;
        buffered_count <= buffered_count + {{(CNT_BITS-TAKE_BITS){1'b0}}, take};
      end
    end else if (cmd.emit) begin
      if (bad) begin
        // Drop the buffer and skip the rest of the stream.
        bit_buffer     <= '0;
        buffered_count <= '0;
        bits_remaining <= rem_drop;
        if (rem_drop == '0) begin
          header_bytes_seen <= '0;
          discarding        <= 1'b0;
        end else begin
          discarding <= 1'b1;
        end
      end else if (done) begin
        bit_buffer        <= '0;
        buffered_count    <= '0;
        bits_remaining    <= '0;
        header_bytes_seen <= '0;
      end else begin
        bit_buffer     <= bit_buffer & keep_mask;
        buffered_count <= count_after;
        bits_remaining <= rem_after;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result.symbol     <= bad ? '0 : sym;
      result.last       <= bad || done || !more;
      result.stream_end <= !bad && done;
      result.error      <= bad;
    end
  end

endmodule

@@ design/hufd_ctrl.sv @@
// ----------------------------------------------------------------------------
// hufd_ctrl
// Sequencer: take a beat, then alternate table read and symbol emit.
// ----------------------------------------------------------------------------
module hufd_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  input  logic                 item_kind,
  output logic                 item_stall,
  input  hufd_pkg::hufd_stat_t stat,
  output hufd_pkg::hufd_cmd_t  cmd
);
  import hufd_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PEEK = 2'd1;
  localparam logic [1:0] ST_EVAL = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  assign item_stall = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (item_valid) begin
          if (item_kind == KIND_BYTE) begin
            cmd.byte_load = 1'b1;
            state_next    = ST_PEEK;
          end else begin
            cmd.table_write = 1'b1;
          end
        end
      end
      ST_PEEK: begin
        if (stat.go) begin
          cmd.table_read = 1'b1;
          state_next     = ST_EVAL;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_EVAL: begin
        // Hold until the output register can take the result.
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = stat.last ? ST_IDLE : ST_PEEK;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ tb/huffman_decode_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_decode_checker
// Watches the item and result channels of the table-driven Huffman decoder.
// Keeps its own decode table and stream state, predicts the symbols each
// accepted beat yields and compares every accepted result field by field.
// ----------------------------------------------------------------------------
module huffman_decode_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  input  logic                item_stall,
  input  hufd_pkg::hufd_in_t  item,
  input  logic                result_valid,
  input  logic                result_stall,
  input  hufd_pkg::hufd_out_t result,
  output int                  mismatches,
  output int                  outstanding
);
  import hufd_pkg::*;

  typedef struct packed {
    logic [SYM_BITS-1:0] sym;
    logic [LEN_BITS-1:0] len;
  } code_entry_t;

  code_entry_t         code_table [TABLE_DEPTH];
  logic [BUF_BITS-1:0] stream_bits;
  int unsigned         held_bits;
  logic [REM_BITS-1:0] bits_left;
  int unsigned         header_seen;
  logic                skipping;
  hufd_out_t           awaited_symbols [$];
  hufd_out_t           want;

  task automatic report_mismatch(input string what);
    $display("t=%0t mismatch: %s", $time, what);
    mismatches++;
  endtask

  function automatic hufd_out_t make_result(input logic [SYM_BITS-1:0] sym,
                                            input logic done, input logic err);
    hufd_out_t r;
    r.symbol     = sym;
    r.last       = 1'b0;
    r.stream_end = done;
    r.error      = err;
    return r;
  endfunction

  // Apply one accepted beat to the shadow state and queue its symbols.
  task automatic predict_beat(input hufd_in_t b);
    int unsigned         room;
    int unsigned         take;
    int                  first;
    logic [INDEX_BITS-1:0] peek;
    code_entry_t         e;
    if (b.kind == KIND_TABLE) begin
      code_table[b.entry_index] = {b.entry_symbol, b.entry_length};
      return;
    end
    if (skipping) begin
      if (bits_left > 8) begin
        bits_left -= 8;
      end else begin
        bits_left   = '0;
        skipping    = 1'b0;
        header_seen = 0;
      end
      return;
    end
    if (header_seen < HDR_BYTES) begin
      if (header_seen == 0) begin
        bits_left   = '0;
        stream_bits = '0;
        held_bits   = 0;
      end
      bits_left = {bits_left[REM_BITS-9:0], b.data_byte};
      header_seen++;
      if (header_seen == HDR_BYTES && bits_left == 0) header_seen = 0;
      return;
    end
    room = bits_left - held_bits;
    take = (room < 8) ? room : 8;
    if (take == 0) return;
    stream_bits = (stream_bits << take) | (BUF_BITS'(b.data_byte) >> (8 - take));
    held_bits += take;
    first = awaited_symbols.size();
    while (header_seen == HDR_BYTES && bits_left > 0 &&
           (held_bits >= INDEX_BITS || held_bits == bits_left)) begin
      if (held_bits >= INDEX_BITS)
        peek = INDEX_BITS'(stream_bits >> (held_bits - INDEX_BITS));
      else
        peek = INDEX_BITS'(stream_bits << (INDEX_BITS - held_bits));
      e = code_table[peek];
      if (e.len == 0 || e.len > INDEX_BITS || e.len > bits_left || e.len > held_bits) begin
        // Bad entry or overrun: drop the buffer, skip what is still undelivered.
        awaited_symbols.push_back(make_result('0, 1'b0, 1'b1));
        bits_left  -= held_bits;
        stream_bits = '0;
        held_bits   = 0;
        if (bits_left == 0) begin
          header_seen = 0;
          skipping    = 1'b0;
        end else begin
          skipping = 1'b1;
        end
        break;
      end
      held_bits  -= e.len;
      stream_bits = stream_bits & ((BUF_BITS'(1) << held_bits) - 1);
      bits_left  -= e.len;
      if (bits_left == 0) begin
        awaited_symbols.push_back(make_result(e.sym, 1'b1, 1'b0));
        stream_bits = '0;
        held_bits   = 0;
        header_seen = 0;
        break;
      end
      awaited_symbols.push_back(make_result(e.sym, 1'b0, 1'b0));
    end
    if (awaited_symbols.size() > first) awaited_symbols[$].last = 1'b1;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      stream_bits = '0;
      held_bits   = 0;
      bits_left   = '0;
      header_seen = 0;
      skipping    = 1'b0;
      mismatches  = 0;
      awaited_symbols.delete();
    end else begin
      if (item_valid && !item_stall) predict_beat(item);
      if (result_valid && !result_stall) begin
        if (awaited_symbols.size() == 0) begin
          report_mismatch($sformatf("unexpected result sym=%0d last=%0b end=%0b err=%0b",
                                    result.symbol, result.last, result.stream_end,
                                    result.error));
        end else begin
          want = awaited_symbols.pop_front();
          if (result.symbol !== want.symbol)
            report_mismatch($sformatf("symbol %0d, expected %0d", result.symbol, want.symbol));
          if (result.last !== want.last)
            report_mismatch($sformatf("last %0b, expected %0b", result.last, want.last));
          if (result.stream_end !== want.stream_end)
            report_mismatch($sformatf("stream_end %0b, expected %0b",
                                      result.stream_end, want.stream_end));
          if (result.error !== want.error)
            report_mismatch($sformatf("error %0b, expected %0b", result.error, want.error));
        end
      end
    end
    outstanding = awaited_symbols.size();
  end

endmodule

@@ tb/tb_huffman_table_decoder_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_huffman_table_decoder_top
// Stimulus and verdict for the table-driven Huffman decoder. Runs directed
// streams (empty stream, unfilled entry, overrun, bad length, extreme codes),
// then random streams under several idle and stall mixes. Before each stream
// it writes every decode table entry the stream will peek at that the table
// does not hold yet. Checking lives in huffman_decode_checker.
// ----------------------------------------------------------------------------
module tb_huffman_table_decoder_top;
  import hufd_pkg::*;

  localparam int CYCLE_LIMIT      = 50000;
  localparam int HOLD_CYCLES      = 400;
  localparam int SETTLE_CYCLES    = 64;
  localparam int PHASE_BEATS      = 24;
  localparam int MAX_STREAM_BITS  = 40;
  localparam int MAX_STREAM_BYTES = MAX_STREAM_BITS / 8;

  logic      clk          = 1'b0;
  logic      rst          = 1'b1;
  logic      item_valid   = 1'b0;
  logic      item_stall;
  hufd_in_t  item         = '0;
  logic      result_valid;
  logic      result_stall = 1'b0;
  hufd_out_t result;

  int   mismatches;
  int   outstanding;
  int   cycle_count     = 0;
  int   beats_sent      = 0;
  int   send_idle_pct   = 0;
  int   recv_stall_pct  = 0;
  logic hold_request    = 1'b0;
  logic hold_active     = 1'b0;

  // What the block's table holds, so streams only peek at written entries.
  bit [ENTRY_BITS-1:0]   shadow_table   [TABLE_DEPTH];
  bit                    shadow_written [TABLE_DEPTH];
  logic [INDEX_BITS-1:0] written_list   [$];

  huffman_table_decoder_top dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  huffman_decode_checker decode_check (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .mismatches   (mismatches),
    .outstanding  (outstanding)
  );

  // 20 ns clock.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Bail out if the run hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("huffman_table_decoder_top verification failed");
      $finish;
    end
  end

  // Receiver: stall at the phase's rate, or solid while a long hold runs.
  always @(negedge clk) begin
    result_stall <= hold_active || ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Long hold: keep the result channel stalled so the block backs up into
  // its item channel while the sender keeps offering beats.
  initial begin
    wait (hold_request);
    @(posedge clk);
    hold_active = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_active = 1'b0;
  end

  function automatic hufd_in_t table_beat(input logic [INDEX_BITS-1:0] idx,
                                          input logic [SYM_BITS-1:0] sym,
                                          input logic [LEN_BITS-1:0] len);
    hufd_in_t b;
    b.kind         = KIND_TABLE;
    b.entry_index  = idx;
    b.entry_symbol = sym;
    b.entry_length = len;
    b.data_byte    = BYTE_BITS'($urandom_range(0, 255));
    return b;
  endfunction

  // Unused entry fields ride along with random content.
  function automatic hufd_in_t byte_beat(input logic [BYTE_BITS-1:0] data);
    hufd_in_t b;
    b.kind         = KIND_BYTE;
    b.entry_index  = INDEX_BITS'($urandom_range(0, TABLE_DEPTH - 1));
    b.entry_symbol = SYM_BITS'($urandom_range(0, 127));
    b.entry_length = LEN_BITS'($urandom_range(0, 15));
    b.data_byte    = data;
    return b;
  endfunction

  // Mostly short codes so bytes decode into several symbols; now and then an
  // unfilled or oversized length.
  function automatic logic [LEN_BITS-1:0] pick_length();
    int unsigned         roll;
    logic [LEN_BITS-1:0] len;
    roll = $urandom_range(0, 99);
    if (roll < 3)
      len = '0;
    else if (roll < 6)
      len = LEN_BITS'($urandom_range(13, 15));
    else if (roll < 70)
      len = LEN_BITS'($urandom_range(1, 3));
    else
      len = LEN_BITS'($urandom_range(4, INDEX_BITS));
    return len;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_beat(input hufd_in_t b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    item       <= b;
    do @(posedge clk); while (item_stall);
    beats_sent++;
    @(negedge clk);
  endtask

  // Send one table beat and track it.
  task automatic write_entry(input logic [INDEX_BITS-1:0] idx,
                             input logic [SYM_BITS-1:0] sym,
                             input logic [LEN_BITS-1:0] len);
    if (!shadow_written[idx]) written_list.push_back(idx);
    shadow_written[idx] = 1'b1;
    shadow_table[idx]   = {len, sym};
    send_beat(table_beat(idx, sym, len));
  endtask

  // Pick the payload, walk the decode the block will do and write each entry
  // it peeks at that is still missing, then send the header (bit count,
  // big-endian) and the bytes it covers. Now and then an unchanged rewrite of
  // a held entry slips in between bytes.
  task automatic send_stream(input int unsigned nbits);
    logic [31:0]           header;
    logic [BYTE_BITS-1:0]  payload [MAX_STREAM_BYTES];
    logic [INDEX_BITS-1:0] idx;
    logic [LEN_BITS-1:0]   len;
    int unsigned           nbytes;
    int unsigned           pos;
    int unsigned           at;
    int unsigned           pick;
    bit                    stop;
    header = nbits;
    nbytes = (nbits + 7) / 8;
    for (int k = 0; k < MAX_STREAM_BYTES; k++) begin
      pick = $urandom_range(0, 9);
      if (pick < 4)
        payload[k] = 8'h00;
      else if (pick < 7)
        payload[k] = 8'hFF;
      else
        payload[k] = BYTE_BITS'($urandom_range(0, 255));
    end
    at   = 0;
    stop = 1'b0;
    while (!stop && at < nbits) begin
      // Peek: the next stream bits, zero past the bit count.
      for (int j = 0; j < INDEX_BITS; j++) begin
        pos = at + unsigned'(j);
        idx[INDEX_BITS-1-j] = (pos < nbits) ? payload[pos / 8][7 - pos % 8] : 1'b0;
      end
      if (!shadow_written[idx])
        write_entry(idx, SYM_BITS'($urandom_range(0, 127)), pick_length());
      len = shadow_table[idx][ENTRY_BITS-1:SYM_BITS];
      if (len == 0 || len > INDEX_BITS || at + len > nbits)
        stop = 1'b1;
      else
        at += len;
    end
    for (int k = 3; k >= 0; k--) send_beat(byte_beat(header[8*k +: 8]));
    for (int unsigned k = 0; k < nbytes; k++) begin
      if ($urandom_range(0, 99) < 12 && written_list.size() != 0) begin
        idx = written_list[$urandom_range(0, written_list.size() - 1)];
        send_beat(table_beat(idx, shadow_table[idx][SYM_BITS-1:0],
                             shadow_table[idx][ENTRY_BITS-1:SYM_BITS]));
      end
      send_beat(byte_beat(payload[k]));
    end
  endtask

  // Drop valid, hold until every expected symbol is back, switch the mix.
  task automatic set_phase(input int idle_pct, input int stall_pct);
    item_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    @(posedge clk);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    @(negedge clk);
  endtask

  initial begin
    int          idle_mix  [4];
    int          stall_mix [4];
    int          phase_start;
    int unsigned nbits;
    int unsigned pick;

    idle_mix  = '{0, 54, 0, 15};
    stall_mix = '{0, 0, 54, 15};

    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty stream, then an unfilled entry hit by an all-zero byte.
    write_entry('0, '0, '0);
    send_stream(0);
    send_beat(byte_beat(8'h00));
    send_beat(byte_beat(8'h00));
    send_beat(byte_beat(8'h00));
    send_beat(byte_beat(8'd8));
    send_beat(byte_beat(8'h00));
    // Longest code with the top symbol, then an overrun on the 4-bit tail.
    write_entry({INDEX_BITS{1'b1}}, 7'd127, LEN_BITS'(INDEX_BITS));
    write_entry(12'hF00, 7'd1, 4'd5);
    send_beat(byte_beat(8'h00));
    send_beat(byte_beat(8'h00));
    send_beat(byte_beat(8'h00));
    send_beat(byte_beat(8'd16));
    send_beat(byte_beat(8'hFF));
    send_beat(byte_beat(8'hFF));
    // Oversized length on a one-bit stream; seven padding bits dropped.
    write_entry(12'h800, 7'd5, 4'd15);
    send_beat(byte_beat(8'h00));
    send_beat(byte_beat(8'h00));
    send_beat(byte_beat(8'h00));
    send_beat(byte_beat(8'd1));
    send_beat(byte_beat(8'h80));
    // Restore usable entries at the spots that zero-padded tails hit most.
    write_entry('0, 7'd0, 4'd1);
    write_entry(12'h800, 7'd5, 4'd1);

    // Random streams, one stretch per idle/stall mix.
    for (int p = 0; p < 4; p++) begin
      set_phase(idle_mix[p], stall_mix[p]);
      phase_start = beats_sent;
      while (beats_sent - phase_start < PHASE_BEATS) begin
        if (p == 0 && beats_sent - phase_start > 8) hold_request = 1'b1;
        pick = $urandom_range(0, 99);
        if (pick < 5)
          nbits = 0;
        else if (pick < 65)
          nbits = $urandom_range(1, 24);
        else
          nbits = $urandom_range(25, MAX_STREAM_BITS);
        if ($urandom_range(0, 9) == 0)
          write_entry(INDEX_BITS'($urandom_range(0, TABLE_DEPTH - 1)),
                      SYM_BITS'($urandom_range(0, 127)), pick_length());
        send_stream(nbits);
      end
    end

    // Drain, then give the block time to show any stray result.
    item_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0)
      $display("huffman_table_decoder_top verification clean");
    else
      $display("huffman_table_decoder_top verification failed");
    $finish;
  end

endmodule
